/* rtl/odo_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the differential drive odometry block.
// No dependencies; the front end, queue, CORDIC, back end and top level use it by scoped names.
package odo_pkg;

    // Fixed-point formats
    localparam int ANGLE_FRAC_BITS  = 13;
    localparam int POS_FRAC_BITS    = 16;
    localparam int RADIUS_FRAC_BITS = 16;
    localparam int FWD_SHIFT        = RADIUS_FRAC_BITS + ANGLE_FRAC_BITS + 1 - POS_FRAC_BITS;
    localparam int Q30_SHIFT        = 30 - ANGLE_FRAC_BITS;

    // Angle constants in Q3.13 and Q30
    localparam logic signed [17:0] PI_ANG      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_ANG  = 18'sd51472;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

    // CORDIC
    localparam int                 CORDIC_STEPS = 30;
    localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032874;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

    // Configuration registers
    localparam logic [15:0] RADIUS_RESET = 16'd2163;
    localparam logic [17:0] TRACK_RESET  = 18'd10486;
    localparam int          CFG_DATA_W   = 18;

    typedef enum logic [0:0] {
        CFG_RADIUS = 1'b0,
        CFG_TRACK  = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        OP_WHEEL    = 1'b0,
        OP_SET_POSE = 1'b1
    } t_op;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        t_op                op;
        logic signed [16:0] sum;    // dr + dl
        logic signed [16:0] diff;   // dr - dl
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [15:0] new_heading;
    } t_item;

    // Wrap to (-pi, pi]; valid for inputs within three half turns
    function automatic logic signed [15:0] wrap_small(input logic signed [17:0] d);
        logic signed [17:0] m;
        begin
            if (d > PI_ANG) begin
                m = d - TWO_PI_ANG;
            end else if (d <= -PI_ANG) begin
                m = d + TWO_PI_ANG;
            end else begin
                m = d;
            end
            return m[15:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647) begin
                return 32'sh7FFF_FFFF;
            end else if (v < -64'sd2147483648) begin
                return 32'sh8000_0000;
            end else begin
                return v[31:0];
            end
        end
    endfunction

    // atan(2^-i) in Q30, rounded
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        begin
            case (i)
                5'd0:    return 30'd843314857;
                5'd1:    return 30'd497837829;
                5'd2:    return 30'd263043837;
                5'd3:    return 30'd133525159;
                5'd4:    return 30'd67021687;
                5'd5:    return 30'd33543516;
                5'd6:    return 30'd16775851;
                5'd7:    return 30'd8388437;
                5'd8:    return 30'd4194283;
                5'd9:    return 30'd2097149;
                5'd10:   return 30'd1048576;
                5'd11:   return 30'd524288;
                5'd12:   return 30'd262144;
                5'd13:   return 30'd131072;
                5'd14:   return 30'd65536;
                5'd15:   return 30'd32768;
                5'd16:   return 30'd16384;
                5'd17:   return 30'd8192;
                5'd18:   return 30'd4096;
                5'd19:   return 30'd2048;
                5'd20:   return 30'd1024;
                5'd21:   return 30'd512;
                5'd22:   return 30'd256;
                5'd23:   return 30'd128;
                5'd24:   return 30'd64;
                5'd25:   return 30'd32;
                5'd26:   return 30'd16;
                5'd27:   return 30'd8;
                5'd28:   return 30'd4;
                5'd29:   return 30'd2;
                default: return 30'd0;
            endcase
        end
    endfunction

endpackage

/* rtl/odo_chan_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the odometry input items and result beats.
// No dependencies.
interface odo_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] left_angle;
    logic signed [15:0] right_angle;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [15:0] new_heading;

    modport source (output valid, op, left_angle, right_angle, new_x, new_y, new_heading,
                    input ready);
    modport sink   (input valid, op, left_angle, right_angle, new_x, new_y, new_heading,
                    output ready);
endinterface

interface odo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    logic signed [15:0] step_rotation;
    logic signed [31:0] step_forward;

    modport source (output valid, pose_x, pose_y, pose_heading, step_rotation, step_forward,
                    input ready);
    modport sink   (input valid, pose_x, pose_y, pose_heading, step_rotation, step_forward,
                    output ready);
endinterface

/* rtl/odo_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input beats, tracks last wheel angles, forms wrapped wheel deltas.
// Depends on odo_pkg and odo_in_if.
module odo_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    odo_in_if.sink         i_item,
    input  logic           i_full,
    output logic           o_push,
    output odo_pkg::t_item o_item
);

    logic signed [15:0] r_last_left;
    logic signed [15:0] r_last_right;
    logic signed [15:0] w_dl;
    logic signed [15:0] w_dr;

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    // wrapped wheel deltas
    always_comb begin
        w_dl = odo_pkg::wrap_small(18'(i_item.left_angle) - 18'(r_last_left));
        w_dr = odo_pkg::wrap_small(18'(i_item.right_angle) - 18'(r_last_right));
    end

    // queue entry
    always_comb begin
        o_item.op          = odo_pkg::t_op'(i_item.op);
        o_item.sum         = 17'(w_dr) + 17'(w_dl);
        o_item.diff        = 17'(w_dr) - 17'(w_dl);
        o_item.new_x       = i_item.new_x;
        o_item.new_y       = i_item.new_y;
        o_item.new_heading = i_item.new_heading;
    end

    // last angles follow wheel updates only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_left  <= '0;
            r_last_right <= '0;
        end else if (o_push && (odo_pkg::t_op'(i_item.op) == odo_pkg::OP_WHEEL)) begin
            r_last_left  <= i_item.left_angle;
            r_last_right <= i_item.right_angle;
        end
    end

endmodule

/* rtl/odo_queue.sv */
`timescale 1ns / 1ps
// Short queue of decoded items between the front and back ends.
// Depends on odo_pkg.
module odo_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  odo_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output odo_pkg::t_item o_item,
    output logic           o_empty
);

    localparam int PW = (odo_pkg::QUEUE_DEPTH > 1) ? $clog2(odo_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(odo_pkg::QUEUE_DEPTH + 1);

    odo_pkg::t_item r_mem [odo_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(odo_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(odo_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(odo_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow a write");

endmodule

/* rtl/odo_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module odo_div #(
    parameter int NW = 50,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   w_sh;
    logic [DW+1:0] w_diff;
    logic          w_ge;

    // shift in next dividend bit, trial subtract
    always_comb begin
        w_sh   = {r_rem, r_num[NW-1]};
        w_diff = {1'b0, w_sh} - {2'b00, r_den};
        w_ge   = !w_diff[DW+1];
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
            r_cnt <= CW'(NW);
        end else if (o_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_num <= {r_num[NW-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

/* rtl/odo_cordic.sv */
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one step per cycle: cosine and sine in Q30 of a Q30 angle.
// Depends on odo_pkg.
module odo_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_angle,
    output logic               o_busy,
    output logic signed [32:0] o_cos,
    output logic signed [32:0] o_sin
);

    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [33:0] r_z;
    logic [4:0]         r_i;
    logic               r_neg;
    logic               r_busy;
    logic signed [32:0] w_xs;
    logic signed [32:0] w_ys;
    logic signed [33:0] w_at;
    logic signed [33:0] w_z0;
    logic signed [33:0] w_zf;
    logic               w_nf;

    // fold the angle into [-pi/2, pi/2]
    always_comb begin
        w_z0 = 34'(i_angle);
        if (w_z0 > odo_pkg::HALF_PI_Q30) begin
            w_zf = w_z0 - odo_pkg::PI_Q30;
            w_nf = 1'b1;
        end else if (w_z0 < -odo_pkg::HALF_PI_Q30) begin
            w_zf = w_z0 + odo_pkg::PI_Q30;
            w_nf = 1'b1;
        end else begin
            w_zf = w_z0;
            w_nf = 1'b0;
        end
    end

    always_comb begin
        w_xs = r_x >>> r_i;
        w_ys = r_y >>> r_i;
        w_at = $signed({4'b0000, odo_pkg::atan_q30(r_i)});
    end

    assign o_busy = r_busy;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_x    <= odo_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= w_zf;
            r_neg  <= w_nf;
            r_i    <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
            r_i <= r_i + 1'b1;
            if (r_i == 5'(odo_pkg::CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

/* rtl/odo_back.sv */
`timescale 1ns / 1ps
// Back end: configuration registers, pose state and the sequencer for one odometry step.
// Depends on odo_pkg, odo_chan_if, odo_div and odo_cordic.
module odo_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_idx,
    input  logic [odo_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_empty,
    input  odo_pkg::t_item                  i_item,
    output logic                            o_pop,
    odo_out_if.source                       o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_RDIV, S_MOD, S_WRAP, S_RCOR, S_P1, S_P2,
        S_DDIV, S_DWAIT, S_DSAT, S_MUL, S_SUM, S_FIN
    } t_state;

    t_state             r_state;
    logic [15:0]        r_radius;
    logic [17:0]        r_track;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;
    logic signed [15:0] r_heading;
    logic signed [15:0] r_rot;
    logic signed [31:0] r_fwd;
    logic               r_out_valid;
    logic signed [33:0] r_prod_d;
    logic signed [33:0] r_prod_s;
    logic               r_rneg;
    logic [31:0]        r_mod;
    logic [4:0]         r_k;
    logic signed [50:0] r_pa;
    logic signed [50:0] r_pb;
    logic signed [31:0] r_dx;
    logic signed [31:0] r_dy;
    logic [1:0]         r_mi;
    logic signed [64:0] r_m [4];
    logic signed [65:0] r_sx;
    logic signed [65:0] r_sy;

    logic [33:0]        w_mag_d;
    logic [33:0]        w_mag_s;
    logic [19:0]        w_fr;
    logic [17:0]        w_trk;
    logic [31:0]        w_rnum;
    logic [31:0]        w_rquot;
    logic               w_rbusy;
    logic [31:0]        w_cand;
    logic signed [17:0] w_mod_s;
    logic signed [15:0] w_rot;
    logic               w_hbusy;
    logic signed [32:0] w_hcos;
    logic signed [32:0] w_hsin;
    logic               w_rcbusy;
    logic signed [32:0] w_rcos;
    logic signed [32:0] w_rsin;
    logic signed [64:0] w_pa;
    logic signed [64:0] w_pb;
    logic [15:0]        w_rot_abs;
    logic [31:0]        w_magr;
    logic [50:0]        w_mag_a;
    logic [50:0]        w_mag_b;
    logic [49:0]        w_num_a;
    logic [49:0]        w_num_b;
    logic [49:0]        w_qa;
    logic [49:0]        w_qb;
    logic               w_busy_a;
    logic               w_busy_b;
    logic               w_neg_a;
    logic               w_neg_b;
    logic signed [32:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [64:0] w_mp;
    logic [65:0]        w_ax;
    logic [65:0]        w_ay;
    logic [65:0]        w_rx;
    logic [65:0]        w_ry;
    logic signed [36:0] w_dxr;
    logic signed [36:0] w_dyr;
    logic signed [37:0] w_nx;
    logic signed [37:0] w_ny;

    assign o_pop = (r_state == S_IDLE) && !i_empty && !r_out_valid;

    // result beat: pose and step registers hold until the next item is taken
    assign o_res.valid         = r_out_valid;
    assign o_res.pose_x        = r_pos_x;
    assign o_res.pose_y        = r_pos_y;
    assign o_res.pose_heading  = r_heading;
    assign o_res.step_rotation = r_rot;
    assign o_res.step_forward  = r_fwd;

    // rotation numerator, forward motion rounding
    always_comb begin
        w_mag_d = r_prod_d[33] ? 34'(-r_prod_d) : 34'(r_prod_d);
        w_mag_s = r_prod_s[33] ? 34'(-r_prod_s) : 34'(r_prod_s);
        w_fr    = 20'((w_mag_s + 34'(1 << (odo_pkg::FWD_SHIFT - 1))) >> odo_pkg::FWD_SHIFT);
        w_trk   = (r_track == '0) ? 18'd1 : r_track;
        w_rnum  = w_mag_d[31:0] + {15'b0, w_trk[17:1]};
    end

    // rotation divider
    odo_div #(.NW(32), .DW(18)) u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_num   (w_rnum),
        .i_den   (w_trk),
        .o_busy  (w_rbusy),
        .o_quot  (w_rquot)
    );

    // remainder by 2*pi, then sign and wrap
    always_comb begin
        w_cand  = {15'b0, odo_pkg::TWO_PI_ANG[16:0]} << r_k;
        w_mod_s = r_rneg ? -$signed({2'b00, r_mod[15:0]}) : $signed({2'b00, r_mod[15:0]});
        w_rot   = odo_pkg::wrap_small(w_mod_s);
    end

    // heading sine/cosine, started with the rotation divide
    odo_cordic u_hcor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_angle ({r_heading, 17'b0}),
        .o_busy  (w_hbusy),
        .o_cos   (w_hcos),
        .o_sin   (w_hsin)
    );

    // step rotation sine/cosine
    odo_cordic u_rcor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_WRAP) && (w_rot != '0)),
        .i_angle ({w_rot, 17'b0}),
        .o_busy  (w_rcbusy),
        .o_cos   (w_rcos),
        .o_sin   (w_rsin)
    );

    // chord products and divide operands
    always_comb begin
        w_pa      = 65'(r_fwd) * 65'(w_rsin);
        w_pb      = 65'(r_fwd) * (65'(odo_pkg::ONE_Q30) - 65'(w_rcos));
        w_rot_abs = r_rot[15] ? 16'(-r_rot) : 16'(r_rot);
        w_magr    = {w_rot_abs[14:0], 17'b0};
        w_mag_a   = r_pa[50] ? 51'(-r_pa) : 51'(r_pa);
        w_mag_b   = r_pb[50] ? 51'(-r_pb) : 51'(r_pb);
        w_num_a   = w_mag_a[49:0] + {19'b0, w_magr[31:1]};
        w_num_b   = w_mag_b[49:0] + {19'b0, w_magr[31:1]};
        w_neg_a   = r_pa[50] ^ r_rot[15];
        w_neg_b   = r_pb[50] ^ r_rot[15];
    end

    odo_div #(.NW(50), .DW(32)) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DDIV),
        .i_num   (w_num_a),
        .i_den   (w_magr),
        .o_busy  (w_busy_a),
        .o_quot  (w_qa)
    );

    odo_div #(.NW(50), .DW(32)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DDIV),
        .i_num   (w_num_b),
        .i_den   (w_magr),
        .o_busy  (w_busy_b),
        .o_quot  (w_qb)
    );

    // shared multiplier for the heading rotation
    always_comb begin
        case (r_mi)
            2'd0:    begin w_ma = w_hcos; w_mb = r_dx; end
            2'd1:    begin w_ma = w_hsin; w_mb = r_dy; end
            2'd2:    begin w_ma = w_hsin; w_mb = r_dx; end
            default: begin w_ma = w_hcos; w_mb = r_dy; end
        endcase
        w_mp = 65'(w_ma) * 65'(w_mb);
    end

    // round Q30 world step to position units and add to the pose
    always_comb begin
        w_ax  = r_sx[65] ? 66'(-r_sx) : 66'(r_sx);
        w_ay  = r_sy[65] ? 66'(-r_sy) : 66'(r_sy);
        w_rx  = w_ax + 66'(1 << 29);
        w_ry  = w_ay + 66'(1 << 29);
        w_dxr = r_sx[65] ? -$signed({1'b0, w_rx[65:30]}) : $signed({1'b0, w_rx[65:30]});
        w_dyr = r_sy[65] ? -$signed({1'b0, w_ry[65:30]}) : $signed({1'b0, w_ry[65:30]});
        w_nx  = 38'(r_pos_x) + 38'(w_dxr);
        w_ny  = 38'(r_pos_y) + 38'(w_dyr);
    end

    // sequencer, pose state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_radius    <= odo_pkg::RADIUS_RESET;
            r_track     <= odo_pkg::TRACK_RESET;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_rot       <= '0;
            r_fwd       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (odo_pkg::t_cfg_idx'(i_cfg_idx))
                    odo_pkg::CFG_RADIUS: r_radius <= i_cfg_data[15:0];
                    odo_pkg::CFG_TRACK:  r_track  <= i_cfg_data[17:0];
                    default: ;
                endcase
            end
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_item.op == odo_pkg::OP_SET_POSE) begin
                            r_pos_x     <= i_item.new_x;
                            r_pos_y     <= i_item.new_y;
                            r_heading   <= odo_pkg::wrap_small(18'(i_item.new_heading));
                            r_rot       <= '0;
                            r_fwd       <= '0;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_prod_d <= 34'($signed({1'b0, r_radius})) * 34'(i_item.diff);
                            r_prod_s <= 34'($signed({1'b0, r_radius})) * 34'(i_item.sum);
                            r_state  <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    // forward motion always fits 32 bits here
                    r_fwd   <= r_prod_s[33] ? -32'(w_fr) : 32'(w_fr);
                    r_rneg  <= r_prod_d[33];
                    r_state <= S_RDIV;
                end
                S_RDIV: begin
                    if (!w_rbusy) begin
                        r_mod   <= w_rquot;
                        r_k     <= 5'd16;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_mod >= w_cand) begin
                        r_mod <= r_mod - w_cand;
                    end
                    r_k <= r_k - 1'b1;
                    if (r_k == '0) begin
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    r_rot <= w_rot;
                    if (w_rot == '0) begin
                        // straight line
                        r_dx    <= r_fwd;
                        r_dy    <= '0;
                        r_mi    <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_RCOR;
                    end
                end
                S_RCOR: begin
                    if (!w_rcbusy) begin
                        r_state <= S_P1;
                    end
                end
                S_P1: begin
                    r_pa    <= w_pa[50:0];
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_pb    <= w_pb[50:0];
                    r_state <= S_DDIV;
                end
                S_DDIV: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (!w_busy_a && !w_busy_b) begin
                        r_state <= S_DSAT;
                    end
                end
                S_DSAT: begin
                    r_dx    <= odo_pkg::sat32(w_neg_a ? -$signed({14'b0, w_qa})
                                                      : $signed({14'b0, w_qa}));
                    r_dy    <= odo_pkg::sat32(w_neg_b ? -$signed({14'b0, w_qb})
                                                      : $signed({14'b0, w_qb}));
                    r_mi    <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_m[r_mi] <= w_mp;
                    r_mi      <= r_mi + 1'b1;
                    if (r_mi == 2'd3) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sx    <= 66'(r_m[0]) - 66'(r_m[1]);
                    r_sy    <= 66'(r_m[2]) + 66'(r_m[3]);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_pos_x     <= odo_pkg::sat32(64'(w_nx));
                    r_pos_y     <= odo_pkg::sat32(64'(w_ny));
                    r_heading   <= odo_pkg::wrap_small(18'(r_heading) + 18'(r_rot));
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_hcor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRAP) |-> !w_hbusy)
        else $error("heading sine/cosine not ready at rotation wrap");
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid))
            |-> ($past(r_state) == S_IDLE || $past(r_state) == S_FIN))
        else $error("result raised outside idle or final step");
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (18'(r_heading) <= odo_pkg::PI_ANG) && (18'(r_heading) > -odo_pkg::PI_ANG))
        else $error("heading out of range");
    a_mod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRAP) |-> (r_mod < 32'(odo_pkg::TWO_PI_ANG)))
        else $error("rotation remainder not reduced");

endmodule

/* rtl/diff_drive_odometry.sv */
`timescale 1ns / 1ps
// Top level of the differential drive odometry block: front end, queue, back end.
// Depends on odo_pkg, odo_chan_if, odo_front, odo_queue and odo_back.
//
//   channel    dir   handshake        beat contents
//   i_item     in    valid/ready      op, left/right angle, new x/y/heading
//   o_result   out   valid/ready      pose x/y/heading, step rotation/forward
//   i_cfg_*    in    write enable     register index, data (no read-back)
//
// A turning wheel update in the back end runs a 32-bit rotation divide, a 17-step reduction
// by 2*pi, a 30-step CORDIC of the step rotation and two parallel 50-bit chord divides.
// A straight wheel update skips the step rotation CORDIC and the chord divides.
// A set-pose item sets the pose in idle. Reset is synchronous and clears pose, wheel angles
// and configuration to their defaults. The front end keeps accepting beats into a
// two-entry queue while a result waits; a stalled result holds the back end in idle.
module diff_drive_odometry (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    odo_in_if.sink                         i_item,
    odo_out_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_idx,
    input  logic [odo_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    odo_pkg::t_item w_push_item;
    odo_pkg::t_item w_pop_item;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;

    odo_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    odo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_pop_item),
        .o_empty (w_empty)
    );

    odo_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_empty    (w_empty),
        .i_item     (w_pop_item),
        .o_pop      (w_pop),
        .o_res      (o_result)
    );

endmodule
